@@ sv/cvh_pkg.sv @@
package cvh_pkg;

	// field width of a coordinate on the ports
	localparam int COORD_W = 32;

	// defaults and upper bound of the top level parameters
	localparam int MAX_POINTS_DEF = 64;
	localparam int COORD_BITS_DEF = 32;
	localparam int MAX_POINTS_LIMIT = 4096;
	localparam int ADDR_MAX_W = $clog2(MAX_POINTS_LIMIT);

	// input word: one point
	typedef struct packed {
		logic signed [COORD_W-1:0] pt_x;
		logic signed [COORD_W-1:0] pt_y;
		logic                      pt_last;
	} pt_word_t;

	// output word: one hull vertex
	typedef struct packed {
		logic signed [COORD_W-1:0] hull_x;
		logic signed [COORD_W-1:0] hull_y;
		logic                      hull_last;
		logic                      overflow;
	} hull_word_t;

	// write data source of the point memory
	typedef enum logic [1:0] {
		WSEL_IN,
		WSEL_RD,
		WSEL_KEY
	} pt_wsel_t;

	// commands from controller to datapath
	typedef struct packed {
		logic                  pt_we;
		pt_wsel_t              pt_wsel;
		logic [ADDR_MAX_W-1:0] pt_waddr;
		logic                  pt_re;
		logic [ADDR_MAX_W-1:0] pt_raddr;
		logic                  st_we;
		logic [ADDR_MAX_W-1:0] st_waddr;
		logic [ADDR_MAX_W-1:0] st_wdata;
		logic                  st_re;
		logic [ADDR_MAX_W-1:0] st_raddr;
		logic                  ld_key;
		logic                  ld_last;
		logic                  ld_c;
		logic                  ld_a;
		logic                  push;
		logic                  pop;
		logic                  ld_diff;
		logic                  ld_prod;
		logic                  out_load;
		logic                  out_last;
		logic                  out_ovf;
	} cvh_cmd_t;

	// status from datapath to controller
	typedef struct packed {
		logic                  key_lt;
		logic                  same;
		logic                  left;
		logic                  out_free;
		logic [ADDR_MAX_W-1:0] st_rdata;
	} cvh_sts_t;

endpackage

@@ sv/cvh_ram.sv @@
module cvh_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// one write port, one registered read port that holds when idle
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata_q <= mem_q[raddr];
		end
	end

	assign rdata = rdata_q;

endmodule

@@ sv/cvh_ctrl.sv @@
module cvh_ctrl
	import cvh_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic     clk,
	input  logic     arst_n,
	input  logic     pt_valid,
	input  logic     pt_last,
	output logic     pt_stall,
	output cvh_cmd_t cmd,
	input  cvh_sts_t sts
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CNT_W = $clog2(MAX_POINTS + 1);

	typedef enum logic [4:0] {
		ST_IDLE,
		ST_S_RDK,
		ST_S_GETK,
		ST_S_CMP,
		ST_S_PUT,
		ST_D_RD,
		ST_D_CHK,
		ST_H_INIT,
		ST_H_RDC,
		ST_H_GETC,
		ST_H_DIF,
		ST_H_MUL,
		ST_H_CMP,
		ST_H_GETA,
		ST_H_LDA,
		ST_H_PUSH,
		ST_L_END,
		ST_U_PRG,
		ST_U_PR,
		ST_E_RDS,
		ST_E_RDP,
		ST_E_OUT
	} state_t;

	state_t           state_q;
	logic [CNT_W-1:0] n_q;
	logic [CNT_W-1:0] i_q;
	logic [CNT_W-1:0] j_q;
	logic [CNT_W-1:0] k_q;
	logic [CNT_W-1:0] top_q;
	logic [CNT_W-1:0] base_q;
	logic [CNT_W-1:0] prc_q;
	logic [IDX_W-1:0] prv_q;
	logic             upper_q;
	logic             drop_q;

	logic [CNT_W-1:0] i_inc;
	logic [CNT_W-1:0] i_dec;
	logic [CNT_W-1:0] j_dec;
	logic [CNT_W-1:0] top_dec;
	logic [CNT_W-1:0] n_dec;
	logic [CNT_W-1:0] prc_dec;
	logic             has_room;
	logic             can_pop;
	logic             can_pop_after;
	logic             i_lt_prv;
	logic             up_push;
	logic             emit_last;

	// shared counter arithmetic and conditions
	assign i_inc = i_q + 1'b1;
	assign i_dec = i_q - 1'b1;
	assign j_dec = j_q - 1'b1;
	assign top_dec = top_q - 1'b1;
	assign n_dec = n_q - 1'b1;
	assign prc_dec = prc_q - 1'b1;
	assign has_room = n_q < CNT_W'(MAX_POINTS);
	assign can_pop = {1'b0, top_q} >= ({1'b0, base_q} + (CNT_W + 1)'(2));
	assign can_pop_after = {1'b0, top_dec} >= ({1'b0, base_q} + (CNT_W + 1)'(2));
	assign i_lt_prv = i_q < CNT_W'(prv_q);
	assign up_push = ((prc_q == '0) || (CNT_W'(prv_q) != i_q)) && (top_q != CNT_W'(MAX_POINTS));
	assign emit_last = i_q == top_dec;

	assign pt_stall = state_q != ST_IDLE;

	// command decode
	always_comb begin
		logic [CNT_W-1:0] a;
		a = '0;
		cmd = '0;
		cmd.pt_wsel = WSEL_IN;
		case (state_q)
			ST_IDLE: begin
				cmd.pt_we = pt_valid && has_room;
				cmd.pt_waddr = ADDR_MAX_W'(n_q[IDX_W-1:0]);
			end
			ST_S_RDK: begin
				cmd.pt_re = 1'b1;
				cmd.pt_raddr = ADDR_MAX_W'(i_q[IDX_W-1:0]);
			end
			ST_S_GETK: begin
				cmd.ld_key = 1'b1;
				cmd.pt_re = 1'b1;
				cmd.pt_raddr = ADDR_MAX_W'(i_dec[IDX_W-1:0]);
			end
			ST_S_CMP: begin
				cmd.pt_we = 1'b1;
				cmd.pt_waddr = ADDR_MAX_W'(j_q[IDX_W-1:0]);
				if (sts.key_lt) begin
					cmd.pt_wsel = WSEL_RD;
					a = j_dec - 1'b1;
					cmd.pt_re = j_dec != '0;
					cmd.pt_raddr = ADDR_MAX_W'(a[IDX_W-1:0]);
				end else begin
					cmd.pt_wsel = WSEL_KEY;
				end
			end
			ST_S_PUT: begin
				cmd.pt_we = 1'b1;
				cmd.pt_wsel = WSEL_KEY;
				cmd.pt_waddr = '0;
			end
			ST_D_RD: begin
				cmd.pt_re = i_q != n_q;
				cmd.pt_raddr = ADDR_MAX_W'(i_q[IDX_W-1:0]);
			end
			ST_D_CHK: begin
				cmd.pt_we = (k_q == '0) || !sts.same;
				cmd.pt_wsel = WSEL_RD;
				cmd.pt_waddr = ADDR_MAX_W'(k_q[IDX_W-1:0]);
				cmd.ld_last = 1'b1;
			end
			ST_H_RDC: begin
				cmd.pt_re = 1'b1;
				cmd.pt_raddr = ADDR_MAX_W'(i_q[IDX_W-1:0]);
			end
			ST_H_GETC: begin
				cmd.ld_c = 1'b1;
			end
			ST_H_DIF: begin
				cmd.ld_diff = 1'b1;
			end
			ST_H_MUL: begin
				cmd.ld_prod = 1'b1;
			end
			ST_H_CMP: begin
				cmd.pop = sts.left;
				a = top_q - CNT_W'(3);
				cmd.st_re = sts.left && can_pop_after;
				cmd.st_raddr = ADDR_MAX_W'(a[IDX_W-1:0]);
			end
			ST_H_GETA: begin
				cmd.pt_re = 1'b1;
				cmd.pt_raddr = sts.st_rdata;
			end
			ST_H_LDA: begin
				cmd.ld_a = 1'b1;
			end
			ST_H_PUSH: begin
				cmd.st_we = !upper_q || up_push;
				cmd.push = !upper_q || up_push;
				cmd.st_waddr = ADDR_MAX_W'(top_q[IDX_W-1:0]);
				cmd.st_wdata = ADDR_MAX_W'(i_q[IDX_W-1:0]);
			end
			ST_L_END: begin
				a = top_q - CNT_W'(2);
				cmd.st_re = 1'b1;
				cmd.st_raddr = ADDR_MAX_W'(a[IDX_W-1:0]);
			end
			ST_U_PR: begin
				a = prc_q - CNT_W'(2);
				cmd.st_re = (prc_q != '0) && i_lt_prv;
				cmd.st_raddr = ADDR_MAX_W'(a[IDX_W-1:0]);
			end
			ST_E_RDS: begin
				cmd.st_re = 1'b1;
				cmd.st_raddr = ADDR_MAX_W'(i_q[IDX_W-1:0]);
			end
			ST_E_RDP: begin
				cmd.pt_re = 1'b1;
				cmd.pt_raddr = sts.st_rdata;
			end
			ST_E_OUT: begin
				cmd.out_load = sts.out_free;
				cmd.out_last = emit_last;
				cmd.out_ovf = drop_q;
			end
			default: begin
				cmd.pt_wsel = WSEL_IN;
			end
		endcase
	end

	// sequencer: load, sort, dedup, lower chain, upper chain, emit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			n_q <= '0;
			i_q <= '0;
			j_q <= '0;
			k_q <= '0;
			top_q <= '0;
			base_q <= '0;
			prc_q <= '0;
			prv_q <= '0;
			upper_q <= 1'b0;
			drop_q <= 1'b0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (pt_valid) begin
						if (has_room) begin
							n_q <= n_q + 1'b1;
						end else begin
							drop_q <= 1'b1;
						end
						if (pt_last) begin
							i_q <= CNT_W'(1);
							state_q <= ST_S_RDK;
						end
					end
				end
				// insertion sort in place
				ST_S_RDK: begin
					if (i_q == n_q) begin
						i_q <= '0;
						k_q <= '0;
						state_q <= ST_D_RD;
					end else begin
						state_q <= ST_S_GETK;
					end
				end
				ST_S_GETK: begin
					j_q <= i_q;
					state_q <= ST_S_CMP;
				end
				ST_S_CMP: begin
					if (sts.key_lt) begin
						j_q <= j_dec;
						if (j_dec == '0) begin
							state_q <= ST_S_PUT;
						end
					end else begin
						i_q <= i_inc;
						state_q <= ST_S_RDK;
					end
				end
				ST_S_PUT: begin
					i_q <= i_inc;
					state_q <= ST_S_RDK;
				end
				// duplicate removal
				ST_D_RD: begin
					if (i_q == n_q) begin
						n_q <= k_q;
						state_q <= ST_H_INIT;
					end else begin
						state_q <= ST_D_CHK;
					end
				end
				ST_D_CHK: begin
					if ((k_q == '0) || !sts.same) begin
						k_q <= k_q + 1'b1;
					end
					i_q <= i_inc;
					state_q <= ST_D_RD;
				end
				// chain building
				ST_H_INIT: begin
					top_q <= '0;
					base_q <= '0;
					i_q <= '0;
					upper_q <= 1'b0;
					state_q <= ST_H_RDC;
				end
				ST_H_RDC: begin
					state_q <= ST_H_GETC;
				end
				ST_H_GETC: begin
					state_q <= can_pop ? ST_H_DIF : ST_H_PUSH;
				end
				ST_H_DIF: begin
					state_q <= ST_H_MUL;
				end
				ST_H_MUL: begin
					state_q <= ST_H_CMP;
				end
				ST_H_CMP: begin
					if (sts.left) begin
						top_q <= top_dec;
						state_q <= can_pop_after ? ST_H_GETA : ST_H_PUSH;
					end else begin
						state_q <= ST_H_PUSH;
					end
				end
				ST_H_GETA: begin
					state_q <= ST_H_LDA;
				end
				ST_H_LDA: begin
					state_q <= ST_H_DIF;
				end
				ST_H_PUSH: begin
					if (!upper_q) begin
						top_q <= top_q + 1'b1;
						if (i_inc == n_q) begin
							state_q <= ST_L_END;
						end else begin
							i_q <= i_inc;
							state_q <= ST_H_RDC;
						end
					end else begin
						if (up_push) begin
							top_q <= top_q + 1'b1;
						end
						if (i_q == '0) begin
							state_q <= ST_E_RDS;
						end else begin
							i_q <= i_dec;
							state_q <= ST_U_PR;
						end
					end
				end
				ST_L_END: begin
					top_q <= top_dec;
					base_q <= top_dec;
					prc_q <= top_dec;
					i_q <= n_dec;
					upper_q <= 1'b1;
					state_q <= ST_U_PRG;
				end
				// walk the lower chain pointer down past the current index
				ST_U_PRG: begin
					prv_q <= sts.st_rdata[IDX_W-1:0];
					state_q <= ST_U_PR;
				end
				ST_U_PR: begin
					if ((prc_q != '0) && i_lt_prv) begin
						prc_q <= prc_dec;
						state_q <= ST_U_PRG;
					end else begin
						state_q <= ST_H_RDC;
					end
				end
				// vertex emission
				ST_E_RDS: begin
					state_q <= ST_E_RDP;
				end
				ST_E_RDP: begin
					state_q <= ST_E_OUT;
				end
				ST_E_OUT: begin
					if (sts.out_free) begin
						if (emit_last) begin
							n_q <= '0;
							drop_q <= 1'b0;
							state_q <= ST_IDLE;
						end else begin
							i_q <= i_inc;
							state_q <= ST_E_RDS;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule

@@ sv/cvh_dp.sv @@
module cvh_dp
	import cvh_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  pt_word_t   pt,
	input  cvh_cmd_t   cmd,
	output cvh_sts_t   sts,
	input  logic       hull_stall,
	output logic       hull_valid,
	output hull_word_t hull
);

	localparam int IDX_W = $clog2(MAX_POINTS);
	localparam int CB = COORD_BITS;
	localparam int PW = 2 * COORD_BITS;
	localparam int DW = COORD_BITS + 1;
	localparam int PROD_W = 2 * COORD_BITS + 2;

	logic [PW-1:0]    pt_wdata;
	logic [PW-1:0]    prd;
	logic [IDX_W-1:0] st_rd;
	logic [PW-1:0]    key_q;
	logic [PW-1:0]    last_q;
	logic [PW-1:0]    pa_q;
	logic [PW-1:0]    pm_q;
	logic [PW-1:0]    pc_q;

	logic signed [CB-1:0] rx, ry, kx, ky;
	logic signed [CB-1:0] ax, ay, mx, my, cx, cy;
	logic signed [DW-1:0] d1_q, d2_q, d3_q, d4_q;
	logic signed [PROD_W-1:0] lh_q, rh_q;

	hull_word_t out_q;
	logic       out_valid_q;
	logic       out_free;

	// point memory write source
	always_comb begin
		case (cmd.pt_wsel)
			WSEL_IN:  pt_wdata = {pt.pt_x[CB-1:0], pt.pt_y[CB-1:0]};
			WSEL_RD:  pt_wdata = prd;
			WSEL_KEY: pt_wdata = key_q;
			default:  pt_wdata = prd;
		endcase
	end

	cvh_ram #(
		.WIDTH(PW),
		.DEPTH(MAX_POINTS)
	) u_pt_ram (
		.clk  (clk),
		.we   (cmd.pt_we),
		.waddr(cmd.pt_waddr[IDX_W-1:0]),
		.wdata(pt_wdata),
		.re   (cmd.pt_re),
		.raddr(cmd.pt_raddr[IDX_W-1:0]),
		.rdata(prd)
	);

	cvh_ram #(
		.WIDTH(IDX_W),
		.DEPTH(MAX_POINTS)
	) u_st_ram (
		.clk  (clk),
		.we   (cmd.st_we),
		.waddr(cmd.st_waddr[IDX_W-1:0]),
		.wdata(cmd.st_wdata[IDX_W-1:0]),
		.re   (cmd.st_re),
		.raddr(cmd.st_raddr[IDX_W-1:0]),
		.rdata(st_rd)
	);

	// coordinate views
	assign rx = prd[PW-1:CB];
	assign ry = prd[CB-1:0];
	assign kx = key_q[PW-1:CB];
	assign ky = key_q[CB-1:0];
	assign ax = pa_q[PW-1:CB];
	assign ay = pa_q[CB-1:0];
	assign mx = pm_q[PW-1:CB];
	assign my = pm_q[CB-1:0];
	assign cx = pc_q[PW-1:CB];
	assign cy = pc_q[CB-1:0];

	// point registers and cross product pipeline
	always_ff @(posedge clk) begin
		if (cmd.ld_key) begin
			key_q <= prd;
		end
		if (cmd.ld_last) begin
			last_q <= prd;
		end
		if (cmd.ld_c) begin
			pc_q <= prd;
		end
		if (cmd.ld_a) begin
			pa_q <= prd;
		end else if (cmd.push) begin
			pa_q <= pm_q;
		end
		if (cmd.push) begin
			pm_q <= pc_q;
		end else if (cmd.pop) begin
			pm_q <= pa_q;
		end
		if (cmd.ld_diff) begin
			d1_q <= DW'(cx) - DW'(ax);
			d2_q <= DW'(my) - DW'(ay);
			d3_q <= DW'(cy) - DW'(ay);
			d4_q <= DW'(mx) - DW'(ax);
		end
		if (cmd.ld_prod) begin
			lh_q <= PROD_W'(d1_q) * PROD_W'(d2_q);
			rh_q <= PROD_W'(d3_q) * PROD_W'(d4_q);
		end
	end

	// output word register
	assign out_free = !out_valid_q || !hull_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!hull_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.out_load) begin
			out_q.hull_x <= COORD_W'(rx);
			out_q.hull_y <= COORD_W'(ry);
			out_q.hull_last <= cmd.out_last;
			out_q.overflow <= cmd.out_ovf;
		end
	end

	assign hull_valid = out_valid_q;
	assign hull = out_q;

	// status back to the controller
	assign sts.key_lt = (kx < rx) || ((kx == rx) && (ky < ry));
	assign sts.same = prd == last_q;
	assign sts.left = lh_q > rh_q;
	assign sts.out_free = out_free;
	assign sts.st_rdata = ADDR_MAX_W'(st_rd);

endmodule

@@ sv/convex_hull_monotone_chain_core.sv @@
// Convex hull of a 2D point set by monotone chain. Points enter one per cycle
// until the word with pt_last set; up to MAX_POINTS are kept and further points
// are dropped, which sets overflow on every vertex of that set. Coordinates use
// the low COORD_BITS bits, sign-extended. The hull comes out counter-clockwise
// from the smallest point, collinear boundary points included, the final vertex
// marked by hull_last. After the final point the block stalls its input while
// it works: it sorts the points by insertion, removes duplicates, builds the
// lower chain and then the upper chain, and outputs the vertices, which the
// receiver may stall.
module convex_hull_monotone_chain_core
	import cvh_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF,
	parameter int COORD_BITS = COORD_BITS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pt_valid,
	output logic       pt_stall,
	input  pt_word_t   pt,
	output logic       hull_valid,
	input  logic       hull_stall,
	output hull_word_t hull
);

	cvh_cmd_t cmd;
	cvh_sts_t sts;

	cvh_ctrl #(
		.MAX_POINTS(MAX_POINTS)
	) u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.pt_valid(pt_valid),
		.pt_last (pt.pt_last),
		.pt_stall(pt_stall),
		.cmd     (cmd),
		.sts     (sts)
	);

	cvh_dp #(
		.MAX_POINTS(MAX_POINTS),
		.COORD_BITS(COORD_BITS)
	) u_dp (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt        (pt),
		.cmd       (cmd),
		.sts       (sts),
		.hull_stall(hull_stall),
		.hull_valid(hull_valid),
		.hull      (hull)
	);

endmodule

@@ sv/cvh_checker.sv @@
module cvh_checker
	import cvh_pkg::*;
(
	input logic       clk,
	input logic       arst_n,
	input logic       pt_valid,
	input logic       pt_stall,
	input pt_word_t   pt,
	input logic       hull_valid,
	input logic       hull_stall,
	input hull_word_t hull
);

	// a final point starts computation, so the next word is held off
	a_last_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		pt_valid && !pt_stall && pt.pt_last |=> pt_stall)
		else $error("input taken right after final point");

	// no new point is taken while a hull is still streaming out
	a_stream_stalls: assert property (@(posedge clk) disable iff (!arst_n)
		hull_valid && !hull_stall && !hull.hull_last |-> pt_stall)
		else $error("input taken during hull output");

	// overflow is one value across a hull
	a_ovf_steady: assert property (@(posedge clk) disable iff (!arst_n)
		hull_valid && !hull_stall && !hull.hull_last |=>
		!hull_valid || (hull.overflow == $past(hull.overflow)))
		else $error("overflow changed within a hull");

	// stalled output word holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		hull_valid && hull_stall |=> hull_valid && $stable(hull))
		else $error("stalled output word changed");

endmodule

bind convex_hull_monotone_chain_core cvh_checker u_cvh_checker (.*);

@@ bench/convex_hull_monotone_chain_checker.sv @@
`timescale 1ns / 1ps

module convex_hull_monotone_chain_checker
	import cvh_pkg::*;
#(
	parameter int MAX_POINTS = MAX_POINTS_DEF
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       pt_valid,
	input  logic       pt_stall,
	input  pt_word_t   pt,
	input  logic       hull_valid,
	input  logic       hull_stall,
	input  hull_word_t hull,
	output int         errors,
	output int         pending,
	output int         sets_done,
	output int         vertices_seen
);

	// points of the set being loaded
	logic signed [COORD_W-1:0] pts_x [MAX_POINTS];
	logic signed [COORD_W-1:0] pts_y [MAX_POINTS];
	int   n_loaded;
	bit   dropped;

	// vertices still to come from the block, oldest first
	hull_word_t hull_expected[$];

	// sorted, deduplicated copy used while building the chains
	logic signed [COORD_W-1:0] sx [MAX_POINTS];
	logic signed [COORD_W-1:0] sy [MAX_POINTS];

	function automatic bit pt_below(logic signed [COORD_W-1:0] ax, logic signed [COORD_W-1:0] ay,
			logic signed [COORD_W-1:0] bx, logic signed [COORD_W-1:0] by);
		return (ax < bx) || (ax == bx && ay < by);
	endfunction

	// point m strictly left of the line a -> c, exact product
	function automatic bit turns_left(int a, int m, int c);
		longint dx_ca, dy_ma, dy_ca, dx_ma;
		logic signed [66:0] lhs, rhs;
		dx_ca = longint'(sx[c]) - longint'(sx[a]);
		dy_ma = longint'(sy[m]) - longint'(sy[a]);
		dy_ca = longint'(sy[c]) - longint'(sy[a]);
		dx_ma = longint'(sx[m]) - longint'(sx[a]);
		lhs = 67'(dx_ca) * 67'(dy_ma);
		rhs = 67'(dy_ca) * 67'(dx_ma);
		return lhs > rhs;
	endfunction

	// sort, dedup and walk both chains; queue the vertices
	task automatic predict_hull();
		int n, k, j, top, lower_len, pr;
		int chain [MAX_POINTS];
		logic signed [COORD_W-1:0] kx, ky;
		hull_word_t w;
		n = n_loaded;
		for (int i = 0; i < n; i++) begin
			kx = pts_x[i];
			ky = pts_y[i];
			j = i;
			while (j > 0 && pt_below(kx, ky, sx[j-1], sy[j-1])) begin
				sx[j] = sx[j-1];
				sy[j] = sy[j-1];
				j--;
			end
			sx[j] = kx;
			sy[j] = ky;
		end
		k = 0;
		for (int i = 0; i < n; i++) begin
			if (k == 0 || sx[i] != sx[k-1] || sy[i] != sy[k-1]) begin
				sx[k] = sx[i];
				sy[k] = sy[i];
				k++;
			end
		end
		n = k;
		top = 0;
		for (int i = 0; i < n; i++) begin
			while (top >= 2 && turns_left(chain[top-2], chain[top-1], i))
				top--;
			chain[top++] = i;
		end
		top--;
		lower_len = top;
		pr = lower_len - 1;
		for (int i = n - 1; i >= 0; i--) begin
			while (top >= lower_len + 2 && turns_left(chain[top-2], chain[top-1], i))
				top--;
			while (pr >= 0 && pt_below(sx[i], sy[i], sx[chain[pr]], sy[chain[pr]]))
				pr--;
			if (pr < 0 || chain[pr] != i) begin
				if (top < MAX_POINTS)
					chain[top++] = i;
			end
		end
		for (int i = 0; i < top; i++) begin
			w.hull_x = sx[chain[i]];
			w.hull_y = sy[chain[i]];
			w.hull_last = (i == top - 1);
			w.overflow = dropped;
			hull_expected.insert(hull_expected.size(), w);
		end
		n_loaded = 0;
		dropped = 0;
	endtask

	// compare one vertex word against the oldest expectation
	task automatic check_vertex(hull_word_t got);
		hull_word_t want;
		if (hull_expected.size() == 0) begin
			$display("%0t: unexpected vertex x=%0d y=%0d last=%0b ovf=%0b", $time,
				got.hull_x, got.hull_y, got.hull_last, got.overflow);
			errors++;
			return;
		end
		want = hull_expected.pop_front();
		if (got.hull_x != want.hull_x) begin
			$display("%0t: hull_x expected %0d got %0d", $time, want.hull_x, got.hull_x);
			errors++;
		end
		if (got.hull_y != want.hull_y) begin
			$display("%0t: hull_y expected %0d got %0d", $time, want.hull_y, got.hull_y);
			errors++;
		end
		if (got.hull_last != want.hull_last) begin
			$display("%0t: hull_last expected %0b got %0b", $time, want.hull_last,
				got.hull_last);
			errors++;
		end
		if (got.overflow != want.overflow) begin
			$display("%0t: overflow expected %0b got %0b", $time, want.overflow, got.overflow);
			errors++;
		end
		if (got.hull_last)
			sets_done++;
		vertices_seen++;
	endtask

	// watch both channels
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			n_loaded = 0;
			dropped = 0;
			hull_expected.delete();
			errors = 0;
			sets_done = 0;
			vertices_seen = 0;
		end else begin
			if (hull_valid && !hull_stall)
				check_vertex(hull);
			if (pt_valid && !pt_stall) begin
				if (n_loaded < MAX_POINTS) begin
					pts_x[n_loaded] = pt.pt_x;
					pts_y[n_loaded] = pt.pt_y;
					n_loaded++;
				end else begin
					dropped = 1;
				end
				if (pt.pt_last)
					predict_hull();
			end
		end
	end

	assign pending = hull_expected.size();

endmodule

@@ bench/convex_hull_monotone_chain_core_test.sv @@
`timescale 1ns / 1ps

module convex_hull_monotone_chain_core_test
	import cvh_pkg::*;
();

	localparam int CAP = MAX_POINTS_DEF;
	localparam int WORD_TARGET = 420;
	localparam longint CYCLE_LIMIT = 600000;

	logic       clk;
	logic       arst_n;
	logic       pt_valid;
	logic       pt_stall;
	pt_word_t   pt;
	logic       hull_valid;
	logic       hull_stall;
	hull_word_t hull;

	int     errors, pending, sets_done, vertices_seen;
	int     words_sent;
	bit     calm;
	int     rx_wait;
	longint cycles;

	convex_hull_monotone_chain_core i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.pt_valid  (pt_valid),
		.pt_stall  (pt_stall),
		.pt        (pt),
		.hull_valid(hull_valid),
		.hull_stall(hull_stall),
		.hull      (hull)
	);

	convex_hull_monotone_chain_checker i_checker (
		.clk          (clk),
		.arst_n       (arst_n),
		.pt_valid     (pt_valid),
		.pt_stall     (pt_stall),
		.pt           (pt),
		.hull_valid   (hull_valid),
		.hull_stall   (hull_stall),
		.hull         (hull),
		.errors       (errors),
		.pending      (pending),
		.sets_done    (sets_done),
		.vertices_seen(vertices_seen)
	);

	initial begin
		clk = 0;
		forever #10 clk = ~clk;
	end

	// cycle limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// receiver stalls a random number of cycles per vertex word
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			hull_stall <= 0;
			rx_wait <= 0;
		end else if (hull_valid && !hull_stall) begin
			rx_wait <= calm ? 0 : $urandom_range(0, 4);
			hull_stall <= 0;
		end else if (rx_wait > 0) begin
			rx_wait <= rx_wait - 1;
			hull_stall <= 1;
		end else begin
			hull_stall <= 0;
		end
	end

	// one point word, after a random gap
	task automatic send_point(logic signed [31:0] x, logic signed [31:0] y, bit last);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 4);
		if (gap > 0) begin
			pt_valid <= 0;
			repeat (gap) @(posedge clk);
		end
		pt_valid <= 1;
		pt <= '{pt_x: x, pt_y: y, pt_last: last};
		do @(posedge clk); while (pt_stall);
		words_sent++;
	endtask

	function automatic logic signed [31:0] pick_coord(int style);
		case (style)
			0: return $signed(32'($urandom_range(0, 8))) - 4;
			1: return $signed(32'($urandom_range(0, 2000))) - 1000;
			2: begin
				case ($urandom_range(0, 2))
					0: return 32'sh8000_0000;
					1: return 32'sh7fff_ffff;
					default: return 0;
				endcase
			end
			default: return $signed($urandom);
		endcase
	endfunction

	// sender idles until every expected vertex has come
	task automatic drain();
		pt_valid <= 0;
		@(posedge clk);
		while (pending != 0) @(posedge clk);
	endtask

	initial begin
		int set_len, style;
		arst_n = 0;
		pt_valid = 0;
		pt = '0;
		calm = 0;
		cycles = 0;
		words_sent = 0;
		repeat (9) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// single point at the positive corner
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 1);
		// repeated point collapses to one vertex
		send_point(5, 5, 0);
		send_point(5, 5, 0);
		send_point(5, 5, 1);
		// collinear points all kept
		send_point(3, 3, 0);
		send_point(0, 0, 0);
		send_point(2, 2, 0);
		send_point(1, 1, 1);
		// extreme square with an interior point and a boundary point
		send_point(32'sh7fff_ffff, 32'sh8000_0000, 0);
		send_point(32'sh8000_0000, 32'sh8000_0000, 0);
		send_point(0, 0, 0);
		send_point(32'sh7fff_ffff, 32'sh7fff_ffff, 0);
		send_point(32'sh8000_0000, 32'sh7fff_ffff, 0);
		send_point(0, 32'sh7fff_ffff, 1);
		// hold the sender until the block has emptied
		drain();

		// random sets: mostly small, some beyond capacity
		while (words_sent < WORD_TARGET) begin
			calm = ($urandom_range(0, 5) == 0);
			style = $urandom_range(0, 3);
			case ($urandom_range(0, 11))
				0: set_len = 1;
				1: set_len = $urandom_range(CAP - 1, CAP + 6);
				default: set_len = $urandom_range(2, 20);
			endcase
			for (int i = 0; i < set_len; i++)
				send_point(pick_coord(style), pick_coord(style), i == set_len - 1);
			if ($urandom_range(0, 3) == 0)
				drain();
		end

		drain();
		repeat (200) @(posedge clk);
		$display("Sent %0d point words; checked %0d hull vertices over %0d sets.",
			words_sent, vertices_seen, sets_done);
		if (errors == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule

@@ filelist.f @@
sv/cvh_pkg.sv
sv/cvh_ram.sv
sv/cvh_ctrl.sv
sv/cvh_dp.sv
sv/convex_hull_monotone_chain_core.sv
sv/cvh_checker.sv
bench/convex_hull_monotone_chain_checker.sv
bench/convex_hull_monotone_chain_core_test.sv
